// ----- rtl/iida_pkg.sv -----
// Shared constants, operation codes and controller/datapath interface types.
package iida_pkg;

  localparam int CAPACITY    = 64;
  localparam int ITEM_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 8;
  localparam int RES_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int MODE_W      = 3;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_CNT_W   = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SWAP   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

  typedef enum logic [1:0] {
    RA_P,
    RA_Q,
    RA_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_P,
    WA_Q,
    WA_CUR
  } wr_sel_t;

  typedef enum logic [1:0] {
    WD_VALUE,
    WD_HOLD_A,
    WD_HOLD_B,
    WD_RDATA
  } wd_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    wr_en;
    wr_sel_t wr_sel;
    wd_sel_t wd_sel;
    logic    cur_init;
    logic    cur_step;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              op_ok;
    logic              more;
    logic              out_free;
  } status_t;

endpackage

// ----- rtl/indexed_insert_delete_array.sv -----
// Top level of the indexed insert/delete array.
//
// Holds an ordered list of up to 64 items of 32 bits in a RAM plus a live count.
// Input channel (in_*): one transaction per request; in_tuser carries the mode
// (insert, read, write, delete, swap, clear), in_tdata the positions and item.
// Result channel (out_*): exactly one transaction per request with ok in
// out_tuser and the returned item and new count in out_tdata.
// Requests are processed one at a time through a single-write, single-read RAM.
// Insert and delete take one RAM read and one RAM write for every item that
// moves. in_tready is high while no request is in progress; the next request
// can be accepted in the cycle after the previous result is registered.
// The result sits in an output register; a stalled receiver does not block
// the next request from being accepted and processed, only from completing.
// Reset (synchronous rst_n) empties the list and drops any pending result;
// RAM contents are not cleared and no clearing pass is needed.
module indexed_insert_delete_array (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] position, [15:8] second_position, [47:16] item_in
  input  logic [iida_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [2:0] mode
  input  logic [iida_pkg::MODE_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] item_out, [38:32] count_now, [39] zero
  output logic [iida_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] ok
  output logic [0:0]                          out_tuser
);

  iida_pkg::cmd_t    cmd;
  iida_pkg::status_t status;

  logic                            ram_wr_en, ram_rd_en;
  logic [iida_pkg::ADDR_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [iida_pkg::ITEM_WIDTH-1:0] ram_wr_data, ram_rd_data;

  iida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  iida_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .status      (status),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  iida_ram #(
    .WIDTH (iida_pkg::ITEM_WIDTH),
    .DEPTH (iida_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

// ----- rtl/iida_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module iida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/iida_ctrl.sv -----
// Sequencing state machine for the insert/delete array.
module iida_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  iida_pkg::status_t status,
  output iida_pkg::cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_RD_P   = 11'b00000000100,
    S_CAP_P  = 11'b00000001000,
    S_RD_Q   = 11'b00000010000,
    S_CAP_Q  = 11'b00000100000,
    S_WR_P   = 11'b00001000000,
    S_WR_Q   = 11'b00010000000,
    S_MV_RD  = 11'b00100000000,
    S_MV_WR  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = rst_n && (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_sel   = iida_pkg::RA_P;
    cmd.wr_sel   = iida_pkg::WA_P;
    cmd.wd_sel   = iida_pkg::WD_VALUE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.op_ok) begin
          state_nxt = S_DONE;
        end else begin
          unique case (status.mode)
            iida_pkg::MODE_INSERT: begin
              cmd.cur_init = 1'b1;
              state_nxt    = S_MV_RD;
            end
            iida_pkg::MODE_READ,
            iida_pkg::MODE_DELETE,
            iida_pkg::MODE_SWAP:   state_nxt = S_RD_P;
            iida_pkg::MODE_WRITE:  state_nxt = S_WR_P;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_RD_P: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = iida_pkg::RA_P;
        state_nxt  = S_CAP_P;
      end
      S_CAP_P: begin
        cmd.cap_a = 1'b1;
        if (status.mode == iida_pkg::MODE_SWAP) begin
          state_nxt = S_RD_Q;
        end else if (status.mode == iida_pkg::MODE_DELETE) begin
          cmd.cur_init = 1'b1;
          state_nxt    = S_MV_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD_Q: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = iida_pkg::RA_Q;
        state_nxt  = S_CAP_Q;
      end
      S_CAP_Q: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_WR_P;
      end
      S_WR_P: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = iida_pkg::WA_P;
        if (status.mode == iida_pkg::MODE_SWAP) begin
          cmd.wd_sel = iida_pkg::WD_HOLD_B;
          state_nxt  = S_WR_Q;
        end else begin
          cmd.wd_sel = iida_pkg::WD_VALUE;
          state_nxt  = S_DONE;
        end
      end
      S_WR_Q: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = iida_pkg::WA_Q;
        cmd.wd_sel = iida_pkg::WD_HOLD_A;
        state_nxt  = S_DONE;
      end
      S_MV_RD: begin
        if (status.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = iida_pkg::RA_NEXT;
          state_nxt  = S_MV_WR;
        end else if (status.mode == iida_pkg::MODE_INSERT) begin
          state_nxt = S_WR_P;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MV_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = iida_pkg::WA_CUR;
        cmd.wd_sel   = iida_pkg::WD_RDATA;
        cmd.cur_step = 1'b1;
        state_nxt    = S_MV_RD;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/iida_dp.sv -----
// Datapath: position resolution, cursor, holding registers, count and result register.
module iida_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [iida_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [iida_pkg::MODE_W-1:0]         in_tuser,
  input  iida_pkg::cmd_t                      cmd,
  output iida_pkg::status_t                   status,
  output logic                                ram_wr_en,
  output logic [iida_pkg::ADDR_W-1:0]         ram_wr_addr,
  output logic [iida_pkg::ITEM_WIDTH-1:0]     ram_wr_data,
  output logic                                ram_rd_en,
  output logic [iida_pkg::ADDR_W-1:0]         ram_rd_addr,
  input  logic [iida_pkg::ITEM_WIDTH-1:0]     ram_rd_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [iida_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [0:0]                          out_tuser
);

  localparam int AW = iida_pkg::ADDR_W;
  localparam int CW = iida_pkg::CNT_W;
  localparam int RW = iida_pkg::RES_W;
  localparam int PW = iida_pkg::POS_W;
  localparam int IW = iida_pkg::ITEM_WIDTH;
  localparam int DW = iida_pkg::DATA_W;

  function automatic logic [RW-1:0] resolve(input logic [PW-1:0] pos,
                                            input logic [CW-1:0] cnt);
    logic [RW-1:0] ext;
    ext = {{(RW-PW){pos[PW-1]}}, pos};
    return pos[PW-1] ? (ext + RW'(cnt)) : ext;
  endfunction

  logic [iida_pkg::MODE_W-1:0] mode_r;
  logic [AW-1:0]               p_r, q_r, cur_r;
  logic                        p_ok_r, q_ok_r, ins_ok_r;
  logic [IW-1:0]               value_r, hold_a_r, hold_b_r;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        out_valid_r;
  logic                        out_ok_r;
  logic [DW-1:0]               out_item_r;
  logic [CW-1:0]               out_cnt_r;

  logic [PW-1:0] pos_in, pos2_in;
  logic [RW-1:0] res_p, res_q, lim_ins, lim_std;
  logic          op_ok, is_ins;

  assign pos_in  = in_tdata[PW-1:0];
  assign pos2_in = in_tdata[2*PW-1:PW];
  assign res_p   = resolve(pos_in, cnt_r);
  assign res_q   = resolve(pos2_in, cnt_r);
  assign lim_std = RW'(cnt_r);
  assign lim_ins = RW'(cnt_r) + RW'(1);
  assign is_ins  = (mode_r == iida_pkg::MODE_INSERT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_tuser;
      p_r      <= res_p[AW-1:0];
      q_r      <= res_q[AW-1:0];
      p_ok_r   <= !res_p[RW-1] && (res_p < lim_std);
      q_ok_r   <= !res_q[RW-1] && (res_q < lim_std);
      ins_ok_r <= !res_p[RW-1] && (res_p < lim_ins) && (cnt_r != CW'(iida_pkg::CAPACITY));
      value_r  <= IW'(in_tdata[2*PW+DW-1:2*PW]);
    end
    if (cmd.cap_a) begin
      hold_a_r <= ram_rd_data;
    end
    if (cmd.cap_b) begin
      hold_b_r <= ram_rd_data;
    end
    if (cmd.cur_init) begin
      cur_r <= is_ins ? AW'(cnt_r) : p_r;
    end else if (cmd.cur_step) begin
      cur_r <= is_ins ? (cur_r - AW'(1)) : (cur_r + AW'(1));
    end
  end

  always_comb begin
    unique case (mode_r)
      iida_pkg::MODE_INSERT: op_ok = ins_ok_r;
      iida_pkg::MODE_READ,
      iida_pkg::MODE_WRITE,
      iida_pkg::MODE_DELETE: op_ok = p_ok_r;
      iida_pkg::MODE_SWAP:   op_ok = p_ok_r && q_ok_r;
      iida_pkg::MODE_CLEAR:  op_ok = 1'b1;
      default:               op_ok = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (op_ok) begin
      if (mode_r == iida_pkg::MODE_INSERT) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (mode_r == iida_pkg::MODE_DELETE) begin
        cnt_nxt = cnt_r - CW'(1);
      end else if (mode_r == iida_pkg::MODE_CLEAR) begin
        cnt_nxt = '0;
      end
    end
  end

  assign status.mode     = mode_r;
  assign status.op_ok    = op_ok;
  assign status.more     = is_ins ? (cur_r > p_r) : ((CW'(cur_r) + CW'(1)) < cnt_r);
  assign status.out_free = !out_valid_r || out_tready;

  assign ram_rd_en = cmd.rd_en;
  always_comb begin
    unique case (cmd.rd_sel)
      iida_pkg::RA_P:    ram_rd_addr = p_r;
      iida_pkg::RA_Q:    ram_rd_addr = q_r;
      iida_pkg::RA_NEXT: ram_rd_addr = is_ins ? (cur_r - AW'(1)) : (cur_r + AW'(1));
      default:           ram_rd_addr = p_r;
    endcase
  end

  assign ram_wr_en = cmd.wr_en;
  always_comb begin
    unique case (cmd.wr_sel)
      iida_pkg::WA_P:   ram_wr_addr = p_r;
      iida_pkg::WA_Q:   ram_wr_addr = q_r;
      iida_pkg::WA_CUR: ram_wr_addr = cur_r;
      default:          ram_wr_addr = p_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      iida_pkg::WD_VALUE:  ram_wr_data = value_r;
      iida_pkg::WD_HOLD_A: ram_wr_data = hold_a_r;
      iida_pkg::WD_HOLD_B: ram_wr_data = hold_b_r;
      iida_pkg::WD_RDATA:  ram_wr_data = ram_rd_data;
      default:             ram_wr_data = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ok_r   <= op_ok;
      out_cnt_r  <= cnt_nxt;
      out_item_r <= (op_ok && (mode_r == iida_pkg::MODE_READ ||
                               mode_r == iida_pkg::MODE_DELETE)) ? DW'(hold_a_r) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {{(iida_pkg::OUT_TDATA_W - DW - iida_pkg::OUT_CNT_W){1'b0}},
                       iida_pkg::OUT_CNT_W'(out_cnt_r), out_item_r};

endmodule
